### rtl/pltm_pkg.sv
// pltm_pkg: shared types, constants and the arctangent table of the path metric unit
// used by every module under rtl and by the checker; depends on nothing
`timescale 1ns / 1ps

package pltm_pkg;

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int DELTA_W = COORD_W + 1;
    localparam int SUM_W   = 48;
    localparam int MIN_W   = 16;

    // cordic and root unit
    localparam int ANGLE_Q     = 30;
    localparam int ANGLE_STEPS = 24;
    localparam int ROOT_STEPS  = 33;
    localparam int STEP_W      = $clog2(ROOT_STEPS);
    localparam int CORD_W      = 36;
    localparam int ANG_W       = 34;
    localparam int RAD_W       = 66;
    localparam int ROOT_W      = 33;
    localparam int REM_W       = 35;
    localparam int SQ_W        = 64;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x_position;
        logic signed [COORD_W-1:0] y_position;
        logic                      first_point;
    } t_in_word;

    typedef struct packed {
        logic [SUM_W-1:0] total_length;
        logic [SUM_W-1:0] total_turn;
    } t_out_word;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_HOLD,
        KIND_SEG
    } t_job_kind;

    typedef struct packed {
        t_job_kind                 kind;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SUM,
        ST_ROOT,
        ST_DECIDE,
        ST_DIFF,
        ST_ACC,
        ST_DONE
    } t_back_state;

    // arctangent of 2^-i in Q30
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = ANG_W'(843314856);
            5'd1:  v = ANG_W'(497837829);
            5'd2:  v = ANG_W'(263043836);
            5'd3:  v = ANG_W'(133525158);
            5'd4:  v = ANG_W'(67021686);
            5'd5:  v = ANG_W'(33543515);
            5'd6:  v = ANG_W'(16775850);
            5'd7:  v = ANG_W'(8388437);
            5'd8:  v = ANG_W'(4194282);
            5'd9:  v = ANG_W'(2097149);
            5'd10: v = ANG_W'(1048575);
            5'd11: v = ANG_W'(524287);
            5'd12: v = ANG_W'(262143);
            5'd13: v = ANG_W'(131071);
            5'd14: v = ANG_W'(65535);
            5'd15: v = ANG_W'(32767);
            5'd16: v = ANG_W'(16383);
            5'd17: v = ANG_W'(8191);
            5'd18: v = ANG_W'(4095);
            5'd19: v = ANG_W'(2047);
            5'd20: v = ANG_W'(1023);
            5'd21: v = ANG_W'(511);
            5'd22: v = ANG_W'(255);
            5'd23: v = ANG_W'(127);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/pltm_front.sv
// pltm_front: takes waypoint words, keeps the previous point and classifies each word
// into a job for the back end; depends on pltm_pkg
`timescale 1ns / 1ps

module pltm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pltm_pkg::t_in_word i_in_word,
    output logic               o_in_stall,
    input  logic               i_q_full,
    output logic               o_push,
    output pltm_pkg::t_job     o_job
);
    import pltm_pkg::*;

    logic signed [COORD_W-1:0] r_prev_x;
    logic signed [COORD_W-1:0] r_prev_y;
    logic                      r_have_prev;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_job.dx = DELTA_W'(i_in_word.x_position) - DELTA_W'(r_prev_x);
        o_job.dy = DELTA_W'(i_in_word.y_position) - DELTA_W'(r_prev_y);
        if (i_in_word.first_point) begin
            o_job.kind = KIND_FIRST;
        end else if (!r_have_prev) begin
            o_job.kind = KIND_HOLD;
        end else begin
            o_job.kind = KIND_SEG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
        end else if (o_push) begin
            r_prev_x    <= i_in_word.x_position;
            r_prev_y    <= i_in_word.y_position;
            r_have_prev <= 1'b1;
        end
    end

endmodule

### rtl/pltm_fifo.sv
// pltm_fifo: short job queue between the front and the back end
// depends on pltm_pkg
`timescale 1ns / 1ps

module pltm_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pltm_pkg::t_job i_wr_job,
    input  logic           i_pop,
    output pltm_pkg::t_job o_rd_job,
    output logic           o_empty,
    output logic           o_full
);
    import pltm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty  = (r_count == '0);
    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;
    assign o_rd_job = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/pltm_back.sv
// pltm_back: segment length by bit-serial square root, heading by vectoring cordic,
// saturating sums and the result register; depends on pltm_pkg
`timescale 1ns / 1ps

module pltm_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pltm_pkg::t_job      i_job,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic [15:0]         i_min_segment,
    output logic                o_out_valid,
    output pltm_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import pltm_pkg::*;

    localparam int HEAD_W = FRAC_BITS + 4;
    localparam int TURN_W = HEAD_W + 2;
    localparam int RND_SH = ANGLE_Q - FRAC_BITS;
    localparam longint PI_FL = (PI_Q30 + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
    localparam logic signed [TURN_W-1:0] PI_F     = TURN_W'(PI_FL);
    localparam logic signed [TURN_W-1:0] TWO_PI_F = TURN_W'(2 * PI_FL);
    localparam logic signed [ANG_W-1:0]  RND_HALF = ANG_W'(longint'(1) <<< (RND_SH - 1));
    localparam logic signed [ANG_W-1:0]  HALF_PI  = ANG_W'(HALF_PI_Q30);

    t_back_state r_state;
    t_back_state n_state;

    logic [COORD_W-1:0]       r_ax, r_ay;
    logic [SQ_W-1:0]          r_sq_x, r_sq_y;
    logic [RAD_W-1:0]         r_rad;
    logic [ROOT_W-1:0]        r_root;
    logic [REM_W-1:0]         r_rem;
    logic signed [CORD_W-1:0] r_cx, r_cy;
    logic signed [ANG_W-1:0]  r_cz;
    logic                     r_zero;
    logic [STEP_W-1:0]        r_step;
    logic signed [HEAD_W-1:0] r_head;
    logic signed [HEAD_W-1:0] r_prev_head;
    logic                     r_have_head;
    logic signed [TURN_W-1:0] r_diff;
    logic [SUM_W-1:0]         r_len_sum, r_turn_sum;
    logic                     r_out_valid;
    t_out_word                r_out_word;

    logic                     out_free;
    logic                     len_ok;
    logic [SQ_W-1:0]          mul_op_sq;
    logic [COORD_W-1:0]       mul_op;
    logic [DELTA_W-1:0]       abs_dx, abs_dy;
    logic signed [CORD_W-1:0] dx_e, dy_e, x0, y0;
    logic signed [ANG_W-1:0]  z0;
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W-1:0]         trial;
    logic                     root_ge;
    logic signed [CORD_W-1:0] xs, ys;
    logic signed [ANG_W-1:0]  atan_v;
    logic signed [ANG_W-1:0]  z_rnd, z_shr;
    logic signed [HEAD_W-1:0] head_now;
    logic signed [TURN_W-1:0] d0, d1, d2;
    logic [TURN_W-1:0]        turn_abs;
    logic [SUM_W:0]           len_tot, turn_tot;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == ST_IDLE) && !i_empty;

    // operand prep and one shared multiplier for the two squares
    assign abs_dx    = i_job.dx[DELTA_W-1] ? DELTA_W'(-i_job.dx) : DELTA_W'(i_job.dx);
    assign abs_dy    = i_job.dy[DELTA_W-1] ? DELTA_W'(-i_job.dy) : DELTA_W'(i_job.dy);
    assign mul_op    = (r_state == ST_MUL_X) ? r_ax : r_ay;
    assign mul_op_sq = SQ_W'(mul_op) * SQ_W'(mul_op);

    // cordic pre-rotation into the right half plane
    always_comb begin
        dx_e = CORD_W'(i_job.dx);
        dy_e = CORD_W'(i_job.dy);
        x0   = dx_e;
        y0   = dy_e;
        z0   = '0;
        if (i_job.dx[DELTA_W-1]) begin
            if (!i_job.dy[DELTA_W-1]) begin
                x0 = dy_e;
                y0 = -dx_e;
                z0 = HALF_PI;
            end else begin
                x0 = -dy_e;
                y0 = dx_e;
                z0 = -HALF_PI;
            end
        end
    end

    // one root digit per cycle
    assign rem_sh  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign root_ge = rem_sh >= (REM_W + 2)'(trial);

    // one cordic rotation per cycle
    assign xs     = r_cx >>> r_step;
    assign ys     = r_cy >>> r_step;
    assign atan_v = atan_q30(r_step[4:0]);

    // rounding of the heading and the wrapped heading change
    assign z_rnd    = r_cz + RND_HALF;
    assign z_shr    = z_rnd >>> RND_SH;
    assign head_now = r_zero ? '0 : $signed(z_shr[HEAD_W-1:0]);
    assign d0       = TURN_W'(r_head) - TURN_W'(r_prev_head);
    assign d1       = (d0 > PI_F) ? d0 - TWO_PI_F : d0;
    assign d2       = (d1 < -PI_F) ? d1 + TWO_PI_F : d1;
    assign turn_abs = r_diff[TURN_W-1] ? TURN_W'(-r_diff) : TURN_W'(r_diff);

    assign len_ok   = r_root >= ROOT_W'(i_min_segment);
    assign len_tot  = {1'b0, r_len_sum} + (SUM_W + 1)'(r_root);
    assign turn_tot = {1'b0, r_turn_sum} + (SUM_W + 1)'(turn_abs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_job.kind == KIND_SEG) ? ST_MUL_X : ST_DONE;
                end
            end
            ST_MUL_X:  n_state = ST_MUL_Y;
            ST_MUL_Y:  n_state = ST_SUM;
            ST_SUM:    n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: n_state = (len_ok && r_have_head) ? ST_DIFF : ST_DONE;
            ST_DIFF:   n_state = ST_ACC;
            ST_ACC:    n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // path state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_sum   <= '0;
            r_turn_sum  <= '0;
            r_prev_head <= '0;
            r_have_head <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_IDLE && !i_empty && i_job.kind == KIND_FIRST) begin
                r_len_sum   <= '0;
                r_turn_sum  <= '0;
                r_prev_head <= '0;
                r_have_head <= 1'b0;
            end
            if (r_state == ST_DECIDE && len_ok) begin
                r_len_sum <= len_tot[SUM_W] ? SUM_MAX : len_tot[SUM_W-1:0];
                if (!r_have_head) begin
                    r_have_head <= 1'b1;
                    r_prev_head <= head_now;
                end
            end
            if (r_state == ST_ACC) begin
                r_turn_sum  <= turn_tot[SUM_W] ? SUM_MAX : turn_tot[SUM_W-1:0];
                r_prev_head <= r_head;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // segment datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ax   <= abs_dx[COORD_W-1:0];
                r_ay   <= abs_dy[COORD_W-1:0];
                r_cx   <= x0;
                r_cy   <= y0;
                r_cz   <= z0;
                r_zero <= (i_job.dx == '0) && (i_job.dy == '0);
            end
            ST_MUL_X: r_sq_x <= mul_op_sq;
            ST_MUL_Y: r_sq_y <= mul_op_sq;
            ST_SUM: begin
                r_rad  <= {1'b0, {1'b0, r_sq_x} + {1'b0, r_sq_y}};
                r_root <= '0;
                r_rem  <= '0;
                r_step <= '0;
            end
            ST_ROOT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], root_ge};
                r_rem  <= root_ge ? REM_W'(rem_sh - (REM_W + 2)'(trial)) : REM_W'(rem_sh);
                r_step <= r_step + 1'b1;
                if (r_step < STEP_W'(ANGLE_STEPS)) begin
                    if (!r_cy[CORD_W-1]) begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + atan_v;
                    end else begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - atan_v;
                    end
                end
            end
            ST_DECIDE: r_head <= head_now;
            ST_DIFF:   r_diff <= d2;
            ST_DONE: begin
                if (out_free) begin
                    r_out_word.total_length <= r_len_sum;
                    r_out_word.total_turn   <= r_turn_sum;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/path_length_and_turn_metric_unit.sv
// path_length_and_turn_metric_unit: top level of the path length and turn metric unit
// depends on pltm_pkg, pltm_front, pltm_fifo and pltm_back
//
// Takes 2-D waypoints (signed, FRAC_BITS fraction bits) one word at a time and returns,
// for every word, the running path length and the running sum of absolute heading
// changes in radians, both 48-bit unsigned with FRAC_BITS fraction bits and saturating.
// A word with first_point set starts a new path and returns zeros. Segments whose length
// in coordinate LSBs is below min_segment (written on i_cfg_wr_en, reset value 1) are not
// counted but still move the previous point. The front end takes a word whenever the
// queue has room and queues a job (QUEUE_DEPTH deep); the back end works one job at a
// time. A segment job runs the 33-step bit-serial square root of the 65-bit squared
// length, with the 24-step cordic for the heading running beside it. Results leave
// through an output register, so the back end moves on as soon as that register is free.
`timescale 1ns / 1ps

module path_length_and_turn_metric_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pltm_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pltm_pkg::t_out_word o_out_word,
    input  logic                i_out_stall,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data
);
    import pltm_pkg::*;

    // minimum counted segment length
    logic [MIN_W-1:0] r_min_segment;

    // front to queue
    logic push;
    t_job push_job;
    logic q_full;

    // queue to back end
    logic pop;
    t_job head_job;
    logic q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_segment <= MIN_W'(1);
        end else if (i_cfg_wr_en) begin
            r_min_segment <= i_cfg_wr_data;
        end
    end

    // classifies words and forms the segment deltas
    pltm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decouples the front from the back end, which works on one job at a time
    pltm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wr_job (push_job),
        .i_pop    (pop),
        .o_rd_job (head_job),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    // length, heading, sums and the output register
    pltm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .i_min_segment (r_min_segment),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word),
        .i_out_stall   (i_out_stall)
    );

endmodule

### rtl/pltm_checker.sv
// pltm_checker: port-level assertions for the path metric unit, bound to the top level
// depends on pltm_pkg and path_length_and_turn_metric_unit
`timescale 1ns / 1ps

module pltm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input pltm_pkg::t_in_word  i_in_word,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input pltm_pkg::t_out_word o_out_word,
    input logic                i_out_stall,
    input logic                i_cfg_wr_en,
    input logic [15:0]         i_cfg_wr_data
);
    import pltm_pkg::*;

    // words taken in and not yet delivered
    logic [2:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed or dropped");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 3'd0)
        else $error("result word without an accepted input word");

    // an idle block returns zero sums for a path start word after the queue and done state
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.first_point && r_pending == 3'd0 && !o_out_valid
        |=> ##2 o_out_valid && o_out_word.total_length == '0
                && o_out_word.total_turn == '0)
        else $error("path start word gave nonzero sums");

endmodule

bind path_length_and_turn_metric_unit pltm_checker u_checker (.*);

### bench/path_length_and_turn_metric_unit_tb.sv
// path_length_and_turn_metric_unit_tb: self-checking bench for the path length and turn unit
// depends on pltm_pkg and path_length_and_turn_metric_unit; a directed table, then random paths
// every returned word is checked against a model of the running totals, or zeros on typed rows
`timescale 1ns / 1ps

module path_length_and_turn_metric_unit_tb;
    import pltm_pkg::*;

    // fraction bits of coordinates and angles
    localparam int FRAC        = 16;
    localparam int ANGLE_SHIFT = 30 - FRAC;

    // pi and pi/2 in Q30 radians
    localparam longint HALF_TURN_Q30    = 64'sd3373259426;
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;

    localparam logic signed [31:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] COORD_MIN = 32'sh80000000;

    // run limits
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int PHASE_WORDS   = 130;
    localparam int RANDOM_PHASES = 7;
    localparam int PRINT_LIMIT   = 40;

    typedef enum logic [0:0] {
        ROW_WORD,
        ROW_CFG
    } t_plan_kind;

    // one line of the directed table: a word to send, or a register write
    typedef struct packed {
        t_plan_kind  kind;
        t_in_word    word;
        logic        typed;
        t_out_word   want;
        logic [15:0] floor_val;
    } t_plan_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    t_in_word    i_in_word     = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic        i_out_stall   = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    // model state of the block
    logic [15:0]        seg_floor;
    logic signed [31:0] last_x;
    logic signed [31:0] last_y;
    bit                 have_last_point;
    longint             last_heading;
    bit                 have_last_heading;
    logic [47:0]        length_acc;
    logic [47:0]        turn_acc;

    // arctangent of 2^-k in Q30
    longint arctan_step [0:23] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    t_out_word pending_totals [$];
    t_out_word oldest_total;
    t_plan_row plan [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        stall_left     = 0;
    bit        calm           = 1'b0;

    path_length_and_turn_metric_unit #(
        .FRAC_BITS(FRAC)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_word    (i_in_word),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .i_out_stall  (i_out_stall),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // behavioural model
    // ---------------------------------------------------------------

    // floor square root of a 66-bit value, two bits per step
    function automatic logic [32:0] floor_root(input logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] root;
        logic [67:0] trial;
        rem  = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem   = (rem << 2) | 68'(v[2*i +: 2]);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[32:0];
    endfunction

    // Q30 radians to FRAC fraction bits, half rounded up
    function automatic longint angle_to_frac(input longint q30);
        return (q30 + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
    endfunction

    // vectoring cordic heading of a segment
    function automatic longint segment_heading(input longint dx, input longint dy);
        longint hx;
        longint hy;
        longint hz;
        longint sx;
        longint sy;
        hx = dx;
        hy = dy;
        hz = 0;
        if (dx == 0 && dy == 0)
            return 0;
        // fold the left half plane onto the right
        if (hx < 0) begin
            if (dy >= 0) begin
                hx = dy;
                hy = -dx;
                hz = QUARTER_TURN_Q30;
            end else begin
                hx = -dy;
                hy = dx;
                hz = -QUARTER_TURN_Q30;
            end
        end
        for (int k = 0; k < 24; k++) begin
            sx = hx >>> k;
            sy = hy >>> k;
            if (hy >= 0) begin
                hx = hx + sy;
                hy = hy - sx;
                hz = hz + arctan_step[k];
            end else begin
                hx = hx - sy;
                hy = hy + sx;
                hz = hz - arctan_step[k];
            end
        end
        return angle_to_frac(hz);
    endfunction

    // sum that sticks at 2^48 - 1
    function automatic logic [47:0] add_clipped(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    // moves the model on by one waypoint and gives the totals it returns
    task automatic advance_path_metrics(input t_in_word w, output t_out_word r);
        longint      ddx;
        longint      ddy;
        longint      hd;
        longint      turn_d;
        longint      pi_frac;
        logic [65:0] ax;
        logic [65:0] ay;
        logic [32:0] seg_len;
        if (w.first_point) begin
            length_acc        = '0;
            turn_acc          = '0;
            have_last_heading = 1'b0;
            last_heading      = 0;
        end else if (have_last_point) begin
            ddx     = longint'(w.x_position) - longint'(last_x);
            ddy     = longint'(w.y_position) - longint'(last_y);
            ax      = 66'(ddx < 0 ? -ddx : ddx);
            ay      = 66'(ddy < 0 ? -ddy : ddy);
            seg_len = floor_root(ax * ax + ay * ay);
            if (seg_len >= {17'b0, seg_floor}) begin
                hd         = segment_heading(ddx, ddy);
                length_acc = add_clipped(length_acc, {15'b0, seg_len});
                if (have_last_heading) begin
                    // heading change wrapped once into [-pi, pi]
                    pi_frac = angle_to_frac(HALF_TURN_Q30);
                    turn_d  = hd - last_heading;
                    if (turn_d > pi_frac)
                        turn_d = turn_d - 2 * pi_frac;
                    if (turn_d < -pi_frac)
                        turn_d = turn_d + 2 * pi_frac;
                    turn_acc = add_clipped(turn_acc, 48'(turn_d < 0 ? -turn_d : turn_d));
                end else begin
                    have_last_heading = 1'b1;
                end
                last_heading = hd;
            end
        end
        last_x          = w.x_position;
        last_y          = w.y_position;
        have_last_point = 1'b1;
        r.total_length  = length_acc;
        r.total_turn    = turn_acc;
    endtask

    // ---------------------------------------------------------------
    // directed table rows
    // ---------------------------------------------------------------

    function automatic t_plan_row word_row(input logic signed [31:0] x,
                                           input logic signed [31:0] y, input logic f);
        t_plan_row p;
        p                  = '0;
        p.kind             = ROW_WORD;
        p.word.x_position  = x;
        p.word.y_position  = y;
        p.word.first_point = f;
        return p;
    endfunction

    // a word whose totals are plainly both zero
    function automatic t_plan_row zeros_row(input logic signed [31:0] x,
                                            input logic signed [31:0] y, input logic f);
        t_plan_row p;
        p       = word_row(x, y, f);
        p.typed = 1'b1;
        return p;
    endfunction

    function automatic t_plan_row cfg_row(input logic [15:0] v);
        t_plan_row p;
        p           = '0;
        p.kind      = ROW_CFG;
        p.floor_val = v;
        return p;
    endfunction

    // appends a row at the end of the table
    task automatic add_row(input t_plan_row p);
        plan.insert(plan.size(), p);
    endtask

    // ---------------------------------------------------------------
    // driving helpers
    // ---------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // offers one word from a falling edge, holds it until taken, books its totals
    task automatic send_word(input t_in_word w, input logic typed, input t_out_word want);
        t_out_word predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        advance_path_metrics(w, predicted);
        pending_totals.insert(pending_totals.size(), typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // register write once every booked word has come back
    task automatic apply_min_segment(input logic [15:0] v);
        i_in_valid <= 1'b0;
        while (pending_totals.size() != 0)
            @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        seg_floor      = v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        // waits once more so a following write starts on a fresh edge
        @(negedge i_clk);
    endtask

    // signed step with magnitude below 2^bits, or any 32-bit value
    function automatic logic [31:0] random_step(input int bits);
        logic [31:0] mag;
        if (bits >= 31)
            return $urandom;
        mag = $urandom_range(0, (1 << bits) - 1);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // ---------------------------------------------------------------
    // receiver: random stall bursts, none started while calm
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // checker: each taken word against the oldest booked totals
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_totals.size() == 0) begin
                note_mismatch($sformatf("word with nothing pending: length %0d turn %0d",
                                        o_out_word.total_length, o_out_word.total_turn));
            end else begin
                oldest_total = pending_totals[0];
                pending_totals.delete(0);
                if (o_out_word.total_length !== oldest_total.total_length)
                    note_mismatch($sformatf("total_length got %0d expected %0d",
                                            o_out_word.total_length,
                                            oldest_total.total_length));
                if (o_out_word.total_turn !== oldest_total.total_turn)
                    note_mismatch($sformatf("total_turn got %0d expected %0d",
                                            o_out_word.total_turn, oldest_total.total_turn));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin
        t_in_word           w;
        logic [15:0]        floor_v;
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        int                 path_left;
        int                 scale;

        // model after reset
        seg_floor         = 16'd1;
        last_x            = '0;
        last_y            = '0;
        have_last_point   = 1'b0;
        last_heading      = 0;
        have_last_heading = 1'b0;
        length_acc        = '0;
        turn_acc          = '0;

        // no previous point yet: stored, sums stay at zero
        add_row(zeros_row(32'sd5, 32'sd7, 1'b0));
        add_row(word_row(32'sd100, 32'sd0, 1'b0));
        // extremes of both coordinates, longest segments
        add_row(zeros_row(COORD_MAX, COORD_MAX, 1'b1));
        add_row(word_row(COORD_MIN, COORD_MIN, 1'b0));
        add_row(word_row(COORD_MAX, COORD_MIN, 1'b0));
        add_row(word_row(COORD_MIN, COORD_MAX, 1'b0));
        add_row(word_row(COORD_MAX, COORD_MAX, 1'b0));
        // repeated point under the reset floor is skipped
        add_row(zeros_row(32'sd0, 32'sd0, 1'b1));
        add_row(zeros_row(32'sd0, 32'sd0, 1'b0));
        // floor of zero: a zero-length segment counts with heading 0
        add_row(cfg_row(16'd0));
        add_row(zeros_row(32'sd0, 32'sd0, 1'b1));
        add_row(word_row(32'sd0, 32'sd0, 1'b0));
        // square walk, headings near pi wrap both ways
        add_row(word_row(32'sd65536, 32'sd0, 1'b0));
        add_row(word_row(32'sd65536, 32'sd65536, 1'b0));
        add_row(word_row(32'sd0, 32'sd65536, 1'b0));
        add_row(word_row(32'sd0, 32'sd0, 1'b0));
        add_row(word_row(-32'sd65536, 32'sd0, 1'b0));
        // highest floor
        add_row(cfg_row(16'hffff));
        add_row(zeros_row(32'sd0, 32'sd0, 1'b1));
        add_row(zeros_row(32'sd1000, 32'sd0, 1'b0));
        add_row(word_row(32'sd70000, 32'sd0, 1'b0));
        add_row(word_row(32'sd70000, -32'sd1, 1'b0));
        add_row(cfg_row(16'd1));

        // synchronous reset, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                apply_min_segment(plan[i].floor_val);
            else
                send_word(plan[i].word, plan[i].typed, plan[i].want);
        end

        // random paths, one floor setting per phase, the last phase without idling
        cur_x = '0;
        cur_y = '0;
        scale = 3;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       floor_v = 16'd0;
                1:       floor_v = 16'hffff;
                2:       floor_v = 16'd1;
                3:       floor_v = 16'($urandom_range(2, 300));
                4:       floor_v = 16'($urandom_range(0, 65535));
                5:       floor_v = 16'($urandom_range(1, 4000));
                default: floor_v = 16'd1;
            endcase
            apply_min_segment(floor_v);
            path_left = 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 40 == 0)
                    calm = (phase == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 12) == 0) begin
                    // noise: any point, first flag at random
                    w.x_position  = $urandom;
                    w.y_position  = $urandom;
                    w.first_point = $urandom_range(0, 1);
                end else if (path_left == 0) begin
                    // new path from a wide or a near start point
                    w.x_position  = $urandom_range(0, 1) ? $urandom : random_step(12);
                    w.y_position  = $urandom_range(0, 1) ? $urandom : random_step(12);
                    w.first_point = 1'b1;
                    path_left     = $urandom_range(3, 20);
                    case ($urandom_range(0, 5))
                        0:       scale = 3;
                        1:       scale = 10;
                        2:       scale = 16;
                        3:       scale = 17;
                        4:       scale = 22;
                        default: scale = 31;
                    endcase
                end else begin
                    path_left--;
                    w.first_point = 1'b0;
                    if ($urandom_range(0, 19) == 0) begin
                        // repeated point
                        w.x_position = cur_x;
                        w.y_position = cur_y;
                    end else begin
                        w.x_position = cur_x + random_step(scale);
                        w.y_position = cur_y + random_step(scale);
                    end
                end
                cur_x = w.x_position;
                cur_y = w.y_position;
                send_word(w, 1'b0, '0);
            end
        end

        // drain, then a quiet spell to catch stray words
        i_in_valid <= 1'b0;
        while (pending_totals.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
